/* hw/rtl/uvci_pkg.sv */
// ----------------------------------------------------------------------------
// uvci_pkg
// Shared types and constants for the unique values / counts / inverse block:
// field widths, result kind codes, opcodes and the per-cell control word.
// ----------------------------------------------------------------------------
package uvci_pkg;

    // fixed field widths on the stream ports
    localparam int IN_VALUE_W  = 32;
    localparam int OUT_SLOT_W  = 7;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_COUNT_W = 16;
    localparam int KIND_W      = 2;

    // output tdata layout, lowest bit first
    localparam int OUT_SLOT_LSB  = 0;
    localparam int OUT_VALUE_LSB = OUT_SLOT_LSB + OUT_SLOT_W;
    localparam int OUT_COUNT_LSB = OUT_VALUE_LSB + OUT_VALUE_W;
    localparam int OUT_OVF_BIT   = OUT_COUNT_LSB + OUT_COUNT_W;
    localparam int OUT_DATA_W    = ((OUT_OVF_BIT + 1 + 7) / 8) * 8;

    // input opcodes
    typedef enum logic {
        OP_ELEMENT = 1'b0,
        OP_FINISH  = 1'b1
    } t_opcode;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INDEX = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    // control word sent to each cell
    typedef struct packed {
        logic load;   // store the key, count becomes one
        logic incr;   // saturating count increment
        logic shift;  // take value and count from the next cell
    } t_cell_ctl;

endpackage

/* hw/rtl/uvci_cell.sv */
// ----------------------------------------------------------------------------
// uvci_cell
// One slot of the distinct-value chain: holds a value and its saturating
// count, registers a bitwise match against the broadcast key, and can take
// the contents of its upper neighbor when the table drains.
// ----------------------------------------------------------------------------
module uvci_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  uvci_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_next_value,
    input  logic [COUNT_WIDTH-1:0] i_next_count,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_hit
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_hit;

    // slot contents
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift) begin
            r_value <= i_next_value;
            r_count <= i_next_count;
        end else if (i_ctl.load) begin
            r_value <= i_key;
            r_count <= COUNT_WIDTH'(1);
        end else if (i_ctl.incr) begin
            if (r_count != {COUNT_WIDTH{1'b1}}) begin
                r_count <= r_count + COUNT_WIDTH'(1);
            end
        end
    end

    // registered compare against the key
    always_ff @(posedge i_clk) begin
        r_hit <= (r_value == i_key);
    end

    assign o_value = r_value;
    assign o_count = r_count;
    assign o_hit   = r_hit;

endmodule

/* hw/rtl/unique_values_counts_inverse.sv */
// ----------------------------------------------------------------------------
// unique_values_counts_inverse
// Streaming distinct-value finder with occurrence counts and inverse index,
// built as a chain of slot cells.
// ----------------------------------------------------------------------------
// One input transfer at a time. A list element passes from acceptance to a
// result in the output register through key capture, a registered compare
// in every cell of the chain, then index resolve and count update, which
// wait while the output is back-pressured. A finish emits one entry per
// stored slot, one per cycle unless the output back-pressures, by shifting
// the chain down toward cell zero, or an empty marker for an empty list.
// The table returns empty after the last entry is loaded.
// Values are compared in their low VALUE_WIDTH bits; at most TABLE_DEPTH
// distinct values are held and further new values report overflow.
module unique_values_counts_inverse #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [31:0] element_value
    input  logic        i_s_tuser,  // [0] opcode
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // [6:0] slot_index, [38:7] distinct_value,
                                    // [54:39] occurrence_count, [55] overflow_flag
    output logic [1:0]  o_m_tuser,  // [1:0] result_kind
    output logic        o_m_tlast   // last_result
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_LOOK,
        S_DRAIN
    } t_state;

    t_state                 r_state;
    logic [SLOT_W-1:0]      r_used;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_ovf;
    logic [VALUE_WIDTH-1:0] r_key;

    logic                                r_o_valid;
    logic [uvci_pkg::OUT_DATA_W-1:0]     r_o_data;
    logic [uvci_pkg::KIND_W-1:0]         r_o_user;
    logic                                r_o_last;

    logic [uvci_pkg::OUT_DATA_W-1:0]     n_o_data;
    logic [uvci_pkg::KIND_W-1:0]         n_o_user;
    logic                                n_o_last;

    logic [VALUE_WIDTH-1:0] w_in_key;
    logic                   w_s_xfer;
    logic                   w_out_free;
    logic                   w_o_load;

    uvci_pkg::t_cell_ctl    w_ctl      [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] w_value    [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] w_count    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hit_raw;
    logic [TABLE_DEPTH-1:0] w_hit_vec;
    logic                   w_found;
    logic [SLOT_W-1:0]      w_hit_idx;
    logic                   w_drain_last;

    logic [uvci_pkg::OUT_VALUE_W-1:0] w_out_value;
    logic [uvci_pkg::OUT_COUNT_W-1:0] w_out_count;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_o_load   = w_out_free && ((r_state == S_LOOK) || (r_state == S_DRAIN));

    // input value to VALUE_WIDTH bits, upper bits zero beyond the port
    always_comb begin
        for (int b = 0; b < VALUE_WIDTH; b++) begin
            w_in_key[b] = (b < uvci_pkg::IN_VALUE_W) ? i_s_tdata[b] : 1'b0;
        end
    end

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_nv;
        logic [COUNT_WIDTH-1:0] w_nc;
        if (g == TABLE_DEPTH - 1) begin : g_end
            assign w_nv = w_value[g];
            assign w_nc = w_count[g];
        end else begin : g_mid
            assign w_nv = w_value[g+1];
            assign w_nc = w_count[g+1];
        end
        uvci_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_key       (r_key),
            .i_next_value(w_nv),
            .i_next_count(w_nc),
            .o_value     (w_value[g]),
            .o_count     (w_count[g]),
            .o_hit       (w_hit_raw[g])
        );
    end

    // hits limited to slots in use, and the binary index of the one-hot hit
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit_vec[i] = w_hit_raw[i] && (SLOT_W'(i) < r_used);
            if (w_hit_vec[i]) begin
                w_hit_idx = w_hit_idx | SLOT_W'(i);
            end
        end
        w_found = |w_hit_vec;
    end

    assign w_drain_last = ((r_idx + SLOT_W'(1)) == r_used);

    // per-cell control
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_ctl[i].shift = (r_state == S_DRAIN) && w_out_free && (r_used != '0);
            w_ctl[i].incr  = (r_state == S_LOOK) && w_out_free && w_hit_vec[i];
            w_ctl[i].load  = (r_state == S_LOOK) && w_out_free && !w_found
                             && (r_used == SLOT_W'(i));
        end
    end

    // head cell contents resized to the output fields
    always_comb begin
        for (int b = 0; b < uvci_pkg::OUT_VALUE_W; b++) begin
            w_out_value[b] = (b < VALUE_WIDTH) ? w_value[0][b] : 1'b0;
        end
        for (int b = 0; b < uvci_pkg::OUT_COUNT_W; b++) begin
            w_out_count[b] = (b < COUNT_WIDTH) ? w_count[0][b] : 1'b0;
        end
    end

    // next result beat: inverse index in S_LOOK, entry or empty marker in S_DRAIN
    always_comb begin
        n_o_data = '0;
        n_o_user = uvci_pkg::KIND_INDEX;
        n_o_last = 1'b1;
        if (r_state == S_LOOK) begin
            priority if (w_found) begin
                n_o_data[uvci_pkg::OUT_SLOT_LSB +: uvci_pkg::OUT_SLOT_W] =
                    uvci_pkg::OUT_SLOT_W'(w_hit_idx);
            end else if (r_used != SLOT_W'(TABLE_DEPTH)) begin
                n_o_data[uvci_pkg::OUT_SLOT_LSB +: uvci_pkg::OUT_SLOT_W] =
                    uvci_pkg::OUT_SLOT_W'(r_used);
            end else begin
                // table full: new value is dropped
                n_o_data[uvci_pkg::OUT_SLOT_LSB +: uvci_pkg::OUT_SLOT_W] =
                    uvci_pkg::OUT_SLOT_W'(TABLE_DEPTH);
                n_o_data[uvci_pkg::OUT_OVF_BIT] = 1'b1;
            end
        end else begin
            n_o_data[uvci_pkg::OUT_OVF_BIT] = r_ovf;
            if (r_used == '0) begin
                // empty list marker
                n_o_user = uvci_pkg::KIND_EMPTY;
            end else begin
                n_o_user = uvci_pkg::KIND_ENTRY;
                n_o_last = w_drain_last;
                n_o_data[uvci_pkg::OUT_SLOT_LSB +: uvci_pkg::OUT_SLOT_W] =
                    uvci_pkg::OUT_SLOT_W'(r_idx);
                n_o_data[uvci_pkg::OUT_VALUE_LSB +: uvci_pkg::OUT_VALUE_W] = w_out_value;
                n_o_data[uvci_pkg::OUT_COUNT_LSB +: uvci_pkg::OUT_COUNT_W] = w_out_count;
            end
        end
    end

    // control FSM and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // output register: take a new beat, or empty once transferred
            if (w_o_load) begin
                r_o_valid <= 1'b1;
                r_o_data  <= n_o_data;
                r_o_user  <= n_o_user;
                r_o_last  <= n_o_last;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_xfer) begin
                        r_key <= w_in_key;
                        r_idx <= '0;
                        if (uvci_pkg::t_opcode'(i_s_tuser) == uvci_pkg::OP_FINISH) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (w_out_free) begin
                        if (!w_found) begin
                            if (r_used != SLOT_W'(TABLE_DEPTH)) begin
                                r_used <= r_used + SLOT_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_DRAIN: begin
                    if (w_out_free) begin
                        if (r_used == '0) begin
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + SLOT_W'(1);
                            if (w_drain_last) begin
                                r_used  <= '0;
                                r_ovf   <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;
    assign o_m_tlast  = r_o_last;

`ifndef SYNTHESIS
    // fill level never passes the table size
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SLOT_W'(TABLE_DEPTH))
        else $error("slot fill level beyond table depth");

    // stored values stay distinct: at most one slot matches
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> $onehot0(w_hit_vec))
        else $error("more than one slot matched the key");

    // overflow index only when the table is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == uvci_pkg::KIND_INDEX) && o_m_tdata[uvci_pkg::OUT_OVF_BIT])
        |-> (r_used == SLOT_W'(TABLE_DEPTH)))
        else $error("overflow reported with free slots");

    // a finished list leaves the table empty
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && (o_m_tuser != uvci_pkg::KIND_INDEX))
        |-> (r_used == '0) && !r_ovf)
        else $error("table not cleared after finish");
`endif

endmodule
